// ----- src/tps_pkg.sv -----
`timescale 1ns / 1ps
// tone pattern sequencer package: payload types, codes and row helpers
// no dependencies; imported by every module of the block

package tps_pkg;

   localparam int TPS_MAX_ROWS = 4;
   localparam int TPS_CSR_W    = 64;
   localparam int TPS_IDX_W    = 2;

   // register indexes
   localparam logic [TPS_IDX_W-1:0] CSR_TONE_FREQS     = 2'd0;
   localparam logic [TPS_IDX_W-1:0] CSR_TONE_DURATIONS = 2'd1;
   localparam logic [TPS_IDX_W-1:0] CSR_ROW_COUNT      = 2'd2;

   // operation codes
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_START = 2'd1;
   localparam logic [1:0] OP_STOP  = 2'd2;

   localparam logic [2:0] ROW_COUNT_RESET = 3'd2;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] now;
      logic [15:0] repeat_count;
   } tps_req_type;

   typedef struct packed {
      logic [15:0] tone_freq;
      logic        tone_enable;
      logic        stopped;
   } tps_rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ACCUM,
      ST_COMMIT,
      ST_EMIT
   } tps_state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic commit;
      logic emit;
   } tps_cmd_type;

   typedef struct packed {
      logic tick_work;
      logic row_last;
      logic out_free;
   } tps_status_type;

   // 16-bit field of a packed four-row register
   function automatic logic [15:0] row_field(input logic [63:0] packed_rows,
                                             input logic [1:0] row);
      logic [15:0] f;
      case (row)
         2'd0:    f = packed_rows[15:0];
         2'd1:    f = packed_rows[31:16];
         2'd2:    f = packed_rows[47:32];
         default: f = packed_rows[63:48];
      endcase
      return f;
   endfunction

endpackage

// ----- src/tps_ctrl.sv -----
`timescale 1ns / 1ps
// tone pattern sequencer controller: state machine issuing datapath commands
// depends on tps_pkg

module tps_ctrl
   import tps_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  tps_status_type status,
   output tps_cmd_type    cmd
);

   tps_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = status.tick_work ? ST_ACCUM : ST_COMMIT;
            end
         end
         ST_ACCUM: begin
            cmd.step = 1'b1;
            if (status.row_last) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- src/tps_dp.sv -----
`timescale 1ns / 1ps
// tone pattern sequencer datapath: registers, duration adder, state update, result register
// depends on tps_pkg

module tps_dp
   import tps_pkg::*;
#(
   parameter int MAX_ROWS = TPS_MAX_ROWS
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  tps_req_type          req_data,
   input  tps_cmd_type          cmd,
   output tps_status_type       status,
   input  logic                 csr_we,
   input  logic [TPS_IDX_W-1:0] csr_index,
   input  logic [TPS_CSR_W-1:0] csr_wdata,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output tps_rsp_type          rsp_data
);

   localparam int ROW_W = $clog2(MAX_ROWS);
   localparam int CNT_W = ROW_W + 1;

   // configuration
   logic [63:0] tone_freqs_ff;
   logic [63:0] tone_durations_ff;
   logic [2:0]  row_count_ff;

   // sequencer state
   logic signed [16:0] rounds_left_ff, rounds_left_in;
   logic [31:0]        deadline_ff, deadline_in;
   logic [ROW_W-1:0]   current_row_ff, current_row_in;
   logic [15:0]        drive_freq_ff, drive_freq_in;
   logic               drive_on_ff, drive_on_in;

   // item in progress
   logic [1:0]       op_ff;
   logic [15:0]      reps_ff;
   logic             round_end_ff;
   logic [31:0]      acc_ff;
   logic [ROW_W-1:0] row_idx_ff;

   logic             rsp_valid_ff;
   tps_rsp_type      rsp_data_ff;

   logic [CNT_W-1:0] rows_used;
   logic [CNT_W-1:0] next_row;
   logic             active;
   logic             add_row;
   logic [15:0]      row_dur;

   // clamp of the row count to 1..MAX_ROWS
   always_comb begin
      if (row_count_ff == 3'd0) begin
         rows_used = CNT_W'(1);
      end else if (row_count_ff > 3'(MAX_ROWS)) begin
         rows_used = CNT_W'(MAX_ROWS);
      end else begin
         rows_used = CNT_W'(row_count_ff);
      end
   end

   assign active   = ~rounds_left_ff[16];
   assign next_row = CNT_W'(current_row_ff) + CNT_W'(1);
   assign row_dur  = row_field(tone_durations_ff, 2'(row_idx_ff));
   assign add_row  = round_end_ff || (CNT_W'(row_idx_ff) >= next_row);

   assign status.tick_work = (req_data.op == OP_TICK) && active;
   assign status.row_last  = (CNT_W'(row_idx_ff) == (rows_used - CNT_W'(1)));
   assign status.out_free  = ~rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         tone_freqs_ff     <= '0;
         tone_durations_ff <= '0;
         row_count_ff      <= ROW_COUNT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TONE_FREQS:     tone_freqs_ff     <= csr_wdata;
            CSR_TONE_DURATIONS: tone_durations_ff <= csr_wdata;
            CSR_ROW_COUNT:      row_count_ff      <= csr_wdata[2:0];
            default:            ;
         endcase
      end
   end

   // item capture and duration accumulation, one row a cycle
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff        <= req_data.op;
         reps_ff      <= req_data.repeat_count;
         round_end_ff <= req_data.now >= deadline_ff;
         acc_ff       <= req_data.now;
         row_idx_ff   <= '0;
      end else if (cmd.step) begin
         if (add_row) begin
            acc_ff <= acc_ff + 32'(row_dur);
         end
         row_idx_ff <= row_idx_ff + ROW_W'(1);
      end
   end

   // state update at commit
   always_comb begin
      rounds_left_in = rounds_left_ff;
      deadline_in    = deadline_ff;
      current_row_in = current_row_ff;
      drive_freq_in  = drive_freq_ff;
      drive_on_in    = drive_on_ff;
      case (op_ff)
         OP_TICK: begin
            if (active) begin
               if (round_end_ff) begin
                  rounds_left_in = rounds_left_ff - 17'sd1;
                  if (rounds_left_ff == 17'sd0) begin
                     drive_on_in   = 1'b0;
                     drive_freq_in = '0;
                  end else begin
                     deadline_in    = acc_ff;
                     current_row_in = '0;
                     drive_freq_in  = row_field(tone_freqs_ff, 2'd0);
                     drive_on_in    = 1'b1;
                  end
               end else if ((next_row < rows_used) && (acc_ff >= deadline_ff)) begin
                  current_row_in = next_row[ROW_W-1:0];
                  drive_freq_in  = row_field(tone_freqs_ff, 2'(next_row[ROW_W-1:0]));
                  drive_on_in    = 1'b1;
               end
            end
         end
         OP_START: begin
            rounds_left_in = signed'({1'b0, reps_ff});
            deadline_in    = '0;
            current_row_in = '0;
         end
         OP_STOP: begin
            rounds_left_in = -17'sd1;
            drive_on_in    = 1'b0;
            drive_freq_in  = '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rounds_left_ff <= -17'sd1;
         deadline_ff    <= '0;
         current_row_ff <= '0;
         drive_freq_ff  <= '0;
         drive_on_ff    <= 1'b0;
      end else if (cmd.commit) begin
         rounds_left_ff <= rounds_left_in;
         deadline_ff    <= deadline_in;
         current_row_ff <= current_row_in;
         drive_freq_ff  <= drive_freq_in;
         drive_on_ff    <= drive_on_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_data_ff.tone_freq   <= drive_on_ff ? drive_freq_ff : 16'd0;
         rsp_data_ff.tone_enable <= drive_on_ff;
         rsp_data_ff.stopped     <= rounds_left_ff[16] || (rounds_left_ff == 17'sd0);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- src/tone_pattern_sequencer.sv -----
`timescale 1ns / 1ps
// Buzzer tone pattern sequencer. Up to MAX_ROWS tone rows (16-bit frequency
// and duration) are written through the csr_ port; row_count picks how many
// are used per round (0 acts as 1, above MAX_ROWS as MAX_ROWS). Each req_
// transaction carries op (tick, start, stop) and gives exactly one rsp_
// transaction with the buzzer frequency, enable and a stopped flag. Start
// loads the repeat count; the first tick after it opens a round, or stops
// at once on a zero count. A tick at or past the round deadline opens the
// next round or stops; otherwise it moves on at most one row once now plus
// the remaining durations reaches the deadline. Time compares are unsigned
// 32-bit and sums wrap. A tick on an active sequence walks the duration
// rows with one adder, one row per cycle; start, stop and idle ticks skip
// the walk. The result sits in an output register, so the next transaction
// is accepted while it waits to be taken. Configuration must be written
// only while no transaction is in flight; the block does not enforce it.
// depends on tps_pkg, tps_ctrl, tps_dp

module tone_pattern_sequencer
   import tps_pkg::*;
#(
   parameter int MAX_ROWS = TPS_MAX_ROWS
)
(
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_valid,
   output logic                 req_ready,
   input  tps_req_type          req_data,
   // response channel
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output tps_rsp_type          rsp_data,
   // configuration writes
   input  logic                 csr_we,
   input  logic [TPS_IDX_W-1:0] csr_index,
   input  logic [TPS_CSR_W-1:0] csr_wdata
);

   tps_cmd_type    cmd;
   tps_status_type status;

   // sequencing of load, duration walk, commit and result hand-off
   tps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // configuration, pattern state and the result register
   tps_dp #(
      .MAX_ROWS (MAX_ROWS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTH
   // one transaction at a time: busy straight after acceptance
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while a transaction is in flight");

   // a silent buzzer never reports a frequency
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.tone_enable) |-> (rsp_data.tone_freq == 16'd0))
      else $error("frequency reported with the buzzer off");

   // every commit is followed by a result hand-off attempt
   assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> !req_ready)
      else $error("controller returned to idle without delivering a result");
`endif

endmodule

// ----- test/tone_pattern_sequencer_test.sv -----
`timescale 1ns / 1ps
// self-checking bench for tone_pattern_sequencer: a directed table, then random phases
// every response is checked against a behavioural predictor held in this file
// depends on tps_pkg and the tone_pattern_sequencer rtl

module tone_pattern_sequencer_test;
   import tps_pkg::*;

   localparam int CLOCK_HALF    = 6;
   localparam int RESET_CYCLES  = 7;
   localparam int SETTLE_CYCLES = 20;      // extra wait once every predicted response is taken
   localparam int HOLD_CYCLES   = 300;     // long receiver stall, fills the output stage
   localparam int PHASES        = 11;
   localparam int PHASE_ITEMS   = 48;
   localparam int DIRECTED_N    = 22;
   localparam int CYCLE_LIMIT   = 400000;

   // codes the package leaves unnamed
   localparam logic [1:0]           OP_UNUSED  = 2'd3;
   localparam logic [TPS_IDX_W-1:0] CSR_UNUSED = 2'd3;

   // row counts for the first random phases: extremes and out-of-range values first
   localparam logic [20:0] ROW_PLAN = {3'd2, 3'd3, 3'd5, 3'd7, 3'd0, 3'd4, 3'd1};

   typedef struct {
      tps_req_type req;
      bit          typed;    // response written into the table
      tps_rsp_type rsp;
      bit          reconf;   // load the directed row set before this transaction
   } tone_case_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   tps_req_type          req_data;
   logic                 rsp_valid;
   logic                 rsp_ready;
   tps_rsp_type          rsp_data;
   logic                 csr_we;
   logic [TPS_IDX_W-1:0] csr_index;
   logic [TPS_CSR_W-1:0] csr_wdata;

   // predictor copy of the registers
   logic [63:0] cfg_freqs;
   logic [63:0] cfg_durs;
   logic [2:0]  cfg_rows;

   // predictor copy of the sequencer state
   logic signed [16:0] rounds_left;
   logic [31:0]        deadline;
   logic [1:0]         cur_row;
   logic [15:0]        drive_freq;
   logic               drive_on;

   tps_rsp_type   tone_due[$];     // predicted responses, oldest first
   tone_case_type tone_cases[DIRECTED_N];

   bit steady;                     // no idling on either side
   bit hold_pending;               // asks the receiver for one long stall
   int mismatch_count;
   int cycle_count;
   int sent_count;
   int checked_count;
   int rounds_opened;
   int row_steps;
   int settings_applied;

   tone_pattern_sequencer u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   // run-away guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, tone_due.size());
         $display("tone_pattern_sequencer test failed");
         $finish;
      end
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (steady)
         return 0;
      if (roll < 55)
         return 0;
      if (roll < 90)
         return $urandom_range(1, 3);
      if (roll < 97)
         return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // next response of the sequencer for one accepted transaction
   function automatic tps_rsp_type tone_predict(input tps_req_type r);
      int          n;
      int          next;
      logic [31:0] acc;
      tps_rsp_type o;
      // row count 0 acts as 1, anything above the row limit as the limit
      if (cfg_rows == 3'd0)
         n = 1;
      else if (int'(cfg_rows) > TPS_MAX_ROWS)
         n = TPS_MAX_ROWS;
      else
         n = int'(cfg_rows);
      case (r.op)
         OP_TICK: begin
            // idle tick leaves everything alone
            if (rounds_left >= 0) begin
               if (r.now >= deadline) begin
                  rounds_left = rounds_left - 17'sd1;
                  if (rounds_left < 0) begin
                     rounds_left = -17'sd1;
                     drive_on    = 1'b0;
                     drive_freq  = '0;
                  end else begin
                     // new round: deadline is now plus every used duration, wrapping
                     acc = r.now;
                     for (int i = 0; i < n; i++)
                        acc = acc + {16'h0, cfg_durs[16*i +: 16]};
                     deadline   = acc;
                     cur_row    = '0;
                     drive_freq = cfg_freqs[15:0];
                     drive_on   = 1'b1;
                     rounds_opened++;
                  end
               end else begin
                  // at most one row on, never past the last used row
                  next = int'(cur_row) + 1;
                  if (next < n) begin
                     acc = r.now;
                     for (int i = next; i < n; i++)
                        acc = acc + {16'h0, cfg_durs[16*i +: 16]};
                     if (acc >= deadline) begin
                        cur_row    = next[1:0];
                        drive_freq = cfg_freqs[16*next +: 16];
                        drive_on   = 1'b1;
                        row_steps++;
                     end
                  end
               end
            end
         end
         OP_START: begin
            // drive is left as it was until the first tick
            rounds_left = $signed({1'b0, r.repeat_count});
            deadline    = '0;
            cur_row     = '0;
         end
         OP_STOP: begin
            rounds_left = -17'sd1;
            drive_on    = 1'b0;
            drive_freq  = '0;
         end
         default: ;
      endcase
      o.tone_freq   = drive_on ? drive_freq : 16'h0;
      o.tone_enable = drive_on;
      o.stopped     = (rounds_left <= 0);
      return o;
   endfunction

   function automatic tone_case_type tone_case(input logic [1:0] op, input logic [31:0] now,
                                               input logic [15:0] reps, input bit typed,
                                               input logic [15:0] freq, input bit en,
                                               input bit stp, input bit reconf);
      tone_case_type c;
      c.req.op           = op;
      c.req.now          = now;
      c.req.repeat_count = reps;
      c.typed            = typed;
      c.rsp.tone_freq    = freq;
      c.rsp.tone_enable  = en;
      c.rsp.stopped      = stp;
      c.reconf           = reconf;
      return c;
   endfunction

   // one register write, mirrored into the predictor; called at a falling edge
   task automatic write_csr(input logic [TPS_IDX_W-1:0] idx, input logic [63:0] val);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         CSR_TONE_FREQS:     cfg_freqs = val;
         CSR_TONE_DURATIONS: cfg_durs  = val;
         CSR_ROW_COUNT:      cfg_rows  = val[2:0];
         default: ;          // unused index writes nothing
      endcase
   endtask

   // offer one transaction, predict its response once it is accepted
   task automatic send_item(input tps_req_type r, input bit typed, input tps_rsp_type typed_rsp);
      int          gap;
      tps_rsp_type p;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data  = r;
      req_valid = 1'b1;
      do
         @(posedge clock);
      while (!req_ready);
      p = tone_predict(r);
      tone_due.push_back(typed ? typed_rsp : p);
      sent_count++;
      @(negedge clock);
   endtask

   // block is idle once every predicted response has been taken
   task automatic wait_idle();
      req_valid = 1'b0;
      while (tone_due.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // receiver: random stalls, plus one long hold-off counted here
   initial begin
      int idle_left;
      int hold_left;
      idle_left = 0;
      hold_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_ready = 1'b0;
            hold_left--;
         end else if (idle_left > 0) begin
            rsp_ready = 1'b0;
            idle_left--;
         end else begin
            rsp_ready = 1'b1;
            idle_left = pick_gap();
         end
      end
   end

   // response checker, field by field against the oldest prediction
   always @(posedge clock) begin
      tps_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (tone_due.size() == 0) begin
            $error("response with no transaction outstanding: freq %h enable %b stopped %b",
                   rsp_data.tone_freq, rsp_data.tone_enable, rsp_data.stopped);
            mismatch_count++;
         end else begin
            want = tone_due.pop_front();
            checked_count++;
            if (rsp_data.tone_freq !== want.tone_freq) begin
               $error("tone_freq: expected %h, got %h", want.tone_freq, rsp_data.tone_freq);
               mismatch_count++;
            end
            if (rsp_data.tone_enable !== want.tone_enable) begin
               $error("tone_enable: expected %b, got %b", want.tone_enable,
                      rsp_data.tone_enable);
               mismatch_count++;
            end
            if (rsp_data.stopped !== want.stopped) begin
               $error("stopped: expected %b, got %b", want.stopped, rsp_data.stopped);
               mismatch_count++;
            end
         end
      end
   end

   // stimulus
   initial begin
      tps_req_type r;
      tps_rsp_type none;
      logic [63:0] freqs;
      logic [63:0] durs;
      logic [2:0]  rows;
      logic [31:0] sim_now;
      int          pick;

      none         = '0;
      req_valid    = 1'b0;
      req_data     = '0;
      csr_we       = 1'b0;
      csr_index    = '0;
      csr_wdata    = '0;
      reset        = 1'b1;
      steady       = 1'b0;
      hold_pending = 1'b0;
      sim_now      = '0;

      // predictor after reset: idle, row count two, rows empty
      cfg_freqs   = '0;
      cfg_durs    = '0;
      cfg_rows    = ROW_COUNT_RESET;
      rounds_left = -17'sd1;
      deadline    = '0;
      cur_row     = '0;
      drive_freq  = '0;
      drive_on    = 1'b0;

      // directed table: op, now, repeat count, typed?, freq, enable, stopped, reload rows?
      tone_cases = '{
         // reset configuration
         tone_case(OP_TICK,   32'd0,          16'd0,      1, 16'h0, 0, 1, 0),  // idle tick
         tone_case(OP_UNUSED, 32'hFFFF_FFFF,  16'hFFFF,   1, 16'h0, 0, 1, 0),  // unused op
         tone_case(OP_STOP,   32'd0,          16'd0,      1, 16'h0, 0, 1, 0),
         tone_case(OP_START,  32'd0,          16'd0,      1, 16'h0, 0, 1, 0),  // zero rounds
         tone_case(OP_TICK,   32'd5,          16'd0,      1, 16'h0, 0, 1, 0),  // stops at once
         tone_case(OP_START,  32'd0,          16'd1,      1, 16'h0, 0, 0, 0),
         tone_case(OP_TICK,   32'd7,          16'd0,      0, 16'h0, 0, 0, 0),  // empty rows
         tone_case(OP_TICK,   32'd7,          16'd0,      0, 16'h0, 0, 0, 0),
         // four rows of 10, 20, 30 and 40 ticks
         tone_case(OP_START,  32'd0,          16'd2,      1, 16'h0, 0, 0, 1),
         tone_case(OP_TICK,   32'd1000,       16'd0,      0, 16'h0, 0, 0, 0),  // opens round
         tone_case(OP_TICK,   32'd1040,       16'd0,      0, 16'h0, 0, 0, 0),
         tone_case(OP_TICK,   32'd1041,       16'd0,      0, 16'h0, 0, 0, 0),
         tone_case(OP_TICK,   32'd1099,       16'd0,      0, 16'h0, 0, 0, 0),
         tone_case(OP_TICK,   32'd1099,       16'd0,      0, 16'h0, 0, 0, 0),  // last row holds
         tone_case(OP_TICK,   32'd1100,       16'd0,      0, 16'h0, 0, 0, 0),  // round end
         tone_case(OP_TICK,   32'd1200,       16'd0,      1, 16'h0, 0, 1, 0),  // all played
         tone_case(OP_START,  32'hFFFF_FFFF,  16'hFFFF,   1, 16'h0, 0, 0, 0),  // most rounds
         tone_case(OP_TICK,   32'hFFFF_FFF0,  16'd0,      0, 16'h0, 0, 0, 0),  // deadline wraps
         tone_case(OP_TICK,   32'hFFFF_FFF5,  16'd0,      0, 16'h0, 0, 0, 0),
         tone_case(OP_TICK,   32'd0,          16'd0,      0, 16'h0, 0, 0, 0),
         tone_case(OP_STOP,   32'd0,          16'hFFFF,   1, 16'h0, 0, 1, 0),
         tone_case(OP_TICK,   32'hFFFF_FFFF,  16'd0,      1, 16'h0, 0, 1, 0)
      };

      repeat (RESET_CYCLES) @(negedge clock);
      reset = 1'b0;

      foreach (tone_cases[k]) begin
         if (tone_cases[k].reconf) begin
            wait_idle();
            write_csr(CSR_TONE_FREQS,     64'hFFFF_9ABC_5678_1234);
            write_csr(CSR_TONE_DURATIONS, 64'h0028_001E_0014_000A);
            write_csr(CSR_ROW_COUNT,      64'd4);
            settings_applied++;
         end
         send_item(tone_cases[k].req, tone_cases[k].typed, tone_cases[k].rsp);
      end

      // random phases, a fresh row set each; sequencer state runs on across them,
      // so a lowered row count can land mid-round
      for (int p = 0; p < PHASES; p++) begin
         wait_idle();
         rows  = (p < 7) ? ROW_PLAN[3*p +: 3] : 3'($urandom_range(0, 7));
         freqs = {$urandom, $urandom};
         if (p == 1)
            freqs = '1;
         else if (p == 2)
            freqs = '0;
         for (int i = 0; i < 4; i++)
            durs[16*i +: 16] = 16'($urandom_range(0, 40));
         if (p == 2)
            durs = '0;
         else if (p == 3)
            durs = '1;
         else if (p == 6)
            durs = {$urandom, $urandom};
         write_csr(CSR_TONE_FREQS, freqs);
         write_csr(CSR_TONE_DURATIONS, durs);
         write_csr(CSR_ROW_COUNT, {61'h0, rows});
         if (p == 0)
            write_csr(CSR_UNUSED, {$urandom, $urandom});
         settings_applied++;

         // phase 4 runs flat out; phase 5 does too but behind a long receiver stall
         steady       = (p == 4 || p == 5);
         hold_pending = (p == 5);

         for (int k = 0; k < PHASE_ITEMS; k++) begin
            pick           = $urandom_range(0, 99);
            r.now          = $urandom;
            r.repeat_count = 16'($urandom);
            if ((k == 0 && $urandom_range(0, 1) == 1) || pick < 6) begin
               // mostly short patterns so rounds end and restart often
               r.op = OP_START;
               pick = $urandom_range(0, 9);
               if (pick < 7)
                  r.repeat_count = 16'($urandom_range(0, 4));
               else if (pick < 9)
                  r.repeat_count = 16'($urandom_range(5, 50));
               else
                  r.repeat_count = 16'($urandom_range(0, 65535));
            end else if (pick < 10) begin
               r.op = OP_STOP;
            end else if (pick < 13) begin
               r.op = OP_UNUSED;
            end else if (pick < 18) begin
               r.op = OP_TICK;     // time out of nowhere
            end else begin
               // well-formed time: creeping forward, now and then a big jump or a wrap
               r.op = OP_TICK;
               pick = $urandom_range(0, 99);
               if (pick < 80)
                  sim_now = sim_now + 32'($urandom_range(0, 24));
               else if (pick < 95)
                  sim_now = sim_now + 32'($urandom_range(0, 70000));
               else
                  sim_now = 32'hFFFF_FF00 + 32'($urandom_range(0, 255));
               r.now = sim_now;
            end
            send_item(r, 1'b0, none);
         end
         steady = 1'b0;
      end

      wait_idle();
      $display("%0d transactions sent, %0d responses checked, %0d row settings",
               sent_count, checked_count, settings_applied);
      $display("%0d rounds opened, %0d row steps, %0d mismatches",
               rounds_opened, row_steps, mismatch_count);
      if (mismatch_count == 0)
         $display("tone_pattern_sequencer test passed");
      else
         $display("tone_pattern_sequencer test failed");
      $finish;
   end

endmodule

// ----- sim.f -----
src/tps_pkg.sv
src/tps_ctrl.sv
src/tps_dp.sv
src/tone_pattern_sequencer.sv
test/tone_pattern_sequencer_test.sv
